[hdl/hsl2rgb_pkg.sv]
// ============================================================================
// hsl2rgb_pkg
// Shared types, constants and helpers for the HSL to RGB pixel converter.
// ============================================================================
`default_nettype none

package hsl2rgb_pkg;

    // Port field widths
    localparam int HUE_W = 9;
    localparam int PCT_W = 15;
    localparam int CHAN_W = 8;

    localparam int PCT_FRAC_BITS_DEFAULT = 8;

    // Unsigned Q1.16 fractions, 1.0 held as 65536
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W = FRAC_BITS + 1;

    typedef logic [HUE_W-1:0] angle_t;
    typedef logic [FRAC_W-1:0] frac_t;
    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [5:0] ramp_t;

    localparam angle_t HUE_MAX = 9'd360;
    localparam angle_t HUE_THIRD = 9'd120;
    localparam angle_t HUE_TWO_THIRDS = 9'd240;
    localparam angle_t SEG_RISE_END = 9'd60;
    localparam angle_t SEG_FLAT_END = 9'd180;
    localparam angle_t SEG_FALL_END = 9'd240;
    localparam ramp_t RAMP_FULL = 6'd60;

    localparam frac_t FRAC_ONE = 17'd65536;
    localparam frac_t FRAC_HALF = 17'd32768;

    // Scaled percent (always < 2^23 after the shift) divided by 100 via reciprocal
    localparam int PCT_NUM_W = 23;
    localparam int PCT_SHIFT = 30;
    localparam logic [23:0] PCT_RECIP = 24'd10737419;

    // Final scale: round(base * 255 / (60 * 65536))
    localparam logic [7:0] SCALE_255 = 8'd255;
    localparam int BASE_W = 22;
    localparam logic [29:0] ROUND_BIAS = 30'd1966080;
    localparam int DIV60_SHIFT = 20;
    localparam logic [14:0] DIV60_RECIP = 15'd17477;
    localparam chan_t CHAN_MAX = 8'd255;

    // Ramp position 0..60 for a channel angle 0..360
    function automatic ramp_t ramp_pos(input angle_t a);
        angle_t fall;
        fall = SEG_FALL_END - a;
        if (a < SEG_RISE_END)
            return a[5:0];
        else if (a < SEG_FLAT_END)
            return RAMP_FULL;
        else if (a < SEG_FALL_END)
            return fall[5:0];
        else
            return '0;
    endfunction

endpackage

`default_nettype wire

[hdl/hsl_to_rgb_converter.sv]
// ============================================================================
// hsl_to_rgb_converter
// Seven-stage pipelined HSL to 8-bit RGB conversion.
// ============================================================================
// Throughput: one pixel per cycle while rgb_ready holds; each stage holds one pixel and advances
// whenever the stage after it is free, so bubbles are squeezed out on stall.
// Reset: rst_n clears all stage valid bits; datapath registers are not reset.
`default_nettype none

module hsl_to_rgb_converter #(
    parameter int PERCENT_FRACTION_BITS = hsl2rgb_pkg::PCT_FRAC_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pix_valid,
    output logic                             pix_ready,
    input  logic [hsl2rgb_pkg::HUE_W-1:0]    hue,
    input  logic [hsl2rgb_pkg::PCT_W-1:0]    saturation,
    input  logic [hsl2rgb_pkg::PCT_W-1:0]    lightness,
    output logic                             rgb_valid,
    input  logic                             rgb_ready,
    output logic [hsl2rgb_pkg::CHAN_W-1:0]   red,
    output logic [hsl2rgb_pkg::CHAN_W-1:0]   green,
    output logic [hsl2rgb_pkg::CHAN_W-1:0]   blue
);
    import hsl2rgb_pkg::*;

    localparam int NUM_STAGES = 7;
    localparam int PCT_FULL_INT = 100 << PERCENT_FRACTION_BITS;
    localparam logic [19:0] PCT_FULL = 20'(PCT_FULL_INT);

    // ------------------------------------------------------------------
    // Stage flow control
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] adv;

    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || rgb_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign pix_ready = adv[0];
    assign rgb_valid = valid_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= pix_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp inputs, scale percent to numerator of /100
    // ------------------------------------------------------------------
    logic [PCT_W-1:0]     sat_cl;
    logic [PCT_W-1:0]     lit_cl;
    logic [30:0]          sat_wide;
    logic [30:0]          lit_wide;
    angle_t               hue_cl;

    angle_t               hue1_reg;
    logic                 zero1_reg;
    logic [PCT_NUM_W-1:0] satn1_reg;
    logic [PCT_NUM_W-1:0] litn1_reg;

    always_comb
    begin
        sat_cl = (20'(saturation) > PCT_FULL) ? PCT_FULL[PCT_W-1:0] : saturation;
        lit_cl = (20'(lightness) > PCT_FULL) ? PCT_FULL[PCT_W-1:0] : lightness;
        sat_wide = {sat_cl, 16'b0} >> PERCENT_FRACTION_BITS;
        lit_wide = {lit_cl, 16'b0} >> PERCENT_FRACTION_BITS;
        hue_cl = (hue > HUE_MAX) ? HUE_MAX : hue;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            hue1_reg  <= hue_cl;
            zero1_reg <= (saturation == '0);
            satn1_reg <= sat_wide[PCT_NUM_W-1:0];
            litn1_reg <= lit_wide[PCT_NUM_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: divide by 100 through reciprocal multiply
    // ------------------------------------------------------------------
    logic [PCT_NUM_W+23:0] sat_prod;
    logic [PCT_NUM_W+23:0] lit_prod;

    angle_t hue2_reg;
    logic   zero2_reg;
    frac_t  s2_reg;
    frac_t  l2_reg;

    assign sat_prod = satn1_reg * PCT_RECIP;
    assign lit_prod = litn1_reg * PCT_RECIP;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            hue2_reg  <= hue1_reg;
            zero2_reg <= zero1_reg;
            s2_reg    <= sat_prod[PCT_SHIFT +: FRAC_W];
            l2_reg    <= lit_prod[PCT_SHIFT +: FRAC_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: l * s
    // ------------------------------------------------------------------
    logic [2*FRAC_W-1:0] ls_prod;

    angle_t hue3_reg;
    logic   zero3_reg;
    frac_t  s3_reg;
    frac_t  l3_reg;
    frac_t  ls3_reg;

    assign ls_prod = l2_reg * s2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            hue3_reg  <= hue2_reg;
            zero3_reg <= zero2_reg;
            s3_reg    <= s2_reg;
            l3_reg    <= l2_reg;
            ls3_reg   <= ls_prod[FRAC_BITS +: FRAC_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: the two temporaries, and grey level
    // ------------------------------------------------------------------
    logic signed [FRAC_W+1:0] t1_s;
    logic signed [FRAC_W+1:0] t2_s;
    frac_t                    t1;
    frac_t                    t2;
    logic [FRAC_W+7:0]        grey_prod;
    chan_t                    grey;

    angle_t hue4_reg;
    logic   zero4_reg;
    frac_t  t1_4_reg;
    frac_t  t2_4_reg;
    chan_t  grey4_reg;

    always_comb
    begin
        if (l3_reg < FRAC_HALF)
            t1_s = $signed({2'b0, l3_reg}) + $signed({2'b0, ls3_reg});
        else
            t1_s = $signed({2'b0, l3_reg}) + $signed({2'b0, s3_reg})
                   - $signed({2'b0, ls3_reg});

        if (t1_s < 0)
            t1 = '0;
        else if (t1_s > $signed({2'b0, FRAC_ONE}))
            t1 = FRAC_ONE;
        else
            t1 = t1_s[FRAC_W-1:0];

        t2_s = $signed({1'b0, l3_reg, 1'b0}) - $signed({2'b0, t1});
        if (t2_s < 0)
            t2 = '0;
        else if (t2_s > $signed({2'b0, FRAC_ONE}))
            t2 = FRAC_ONE;
        else
            t2 = t2_s[FRAC_W-1:0];

        // truncated grey, l = 1.0 lands exactly on 255
        grey_prod = l3_reg * SCALE_255;
        grey = (grey_prod[FRAC_W+7:FRAC_BITS] > 9'(CHAN_MAX))
               ? CHAN_MAX : grey_prod[FRAC_BITS +: CHAN_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            hue4_reg  <= hue3_reg;
            zero4_reg <= zero3_reg;
            t1_4_reg  <= t1;
            t2_4_reg  <= t2;
            grey4_reg <= grey;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: per channel angle and ramp, base = t2*60 + (t1-t2)*x
    // ------------------------------------------------------------------
    angle_t                   ang [3];
    ramp_t                    xpos [3];
    logic signed [FRAC_W:0]   diff;
    logic signed [24:0]       t2x60;
    logic signed [24:0]       dx [3];
    logic signed [24:0]       base_s [3];
    logic [BASE_W-1:0]        base [3];

    logic              zero5_reg;
    chan_t             grey5_reg;
    logic [BASE_W-1:0] base5_reg [3];

    always_comb
    begin
        // red = hue + 120, green = hue, blue = hue - 120, wrapped into 0..360
        ang[0] = (hue4_reg > HUE_TWO_THIRDS) ? hue4_reg - HUE_TWO_THIRDS
                                             : hue4_reg + HUE_THIRD;
        ang[1] = hue4_reg;
        ang[2] = (hue4_reg < HUE_THIRD) ? hue4_reg + HUE_TWO_THIRDS
                                        : hue4_reg - HUE_THIRD;

        diff  = $signed({1'b0, t1_4_reg}) - $signed({1'b0, t2_4_reg});
        t2x60 = 25'($signed({1'b0, t2_4_reg})) * 25'sd60;

        for (int c = 0; c < 3; c++)
        begin
            xpos[c]   = ramp_pos(ang[c]);
            dx[c]     = 25'(diff) * 25'($signed({1'b0, xpos[c]}));
            base_s[c] = t2x60 + dx[c];
            base[c]   = (base_s[c] < 0) ? '0 : base_s[c][BASE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            zero5_reg <= zero4_reg;
            grey5_reg <= grey4_reg;
            for (int c = 0; c < 3; c++)
            begin
                base5_reg[c] <= base[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: scale by 255, add half, drop the 2^16 part of the divisor
    // ------------------------------------------------------------------
    logic [29:0] scaled [3];

    logic        zero6_reg;
    chan_t       grey6_reg;
    logic [13:0] z6_reg [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            scaled[c] = 30'(base5_reg[c]) * 30'(SCALE_255) + ROUND_BIAS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            zero6_reg <= zero5_reg;
            grey6_reg <= grey5_reg;
            for (int c = 0; c < 3; c++)
            begin
                z6_reg[c] <= scaled[c][FRAC_BITS +: 14];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: divide by 60 via reciprocal, clamp, select grey
    // ------------------------------------------------------------------
    logic [28:0] qprod [3];
    logic [8:0]  quot [3];
    chan_t       chan [3];

    chan_t red_reg;
    chan_t green_reg;
    chan_t blue_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            qprod[c] = z6_reg[c] * DIV60_RECIP;
            quot[c]  = qprod[c][DIV60_SHIFT +: 9];
            chan[c]  = (quot[c] > 9'(CHAN_MAX)) ? CHAN_MAX : quot[c][CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            red_reg   <= zero6_reg ? grey6_reg : chan[0];
            green_reg <= zero6_reg ? grey6_reg : chan[1];
            blue_reg  <= zero6_reg ? grey6_reg : chan[2];
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire

[bench/hsl_rgb_scoreboard.sv]
// ----------------------------------------------------------------------------
// hsl_rgb_scoreboard
// Watches both handshake channels of the HSL to RGB converter, predicts the
// RGB value of every accepted request and compares it with each result.
// ----------------------------------------------------------------------------
module hsl_rgb_scoreboard #(
    parameter int PCT_FRAC_BITS = hsl2rgb_pkg::PCT_FRAC_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    input  logic                            pix_ready,
    input  logic [hsl2rgb_pkg::HUE_W-1:0]   hue,
    input  logic [hsl2rgb_pkg::PCT_W-1:0]   saturation,
    input  logic [hsl2rgb_pkg::PCT_W-1:0]   lightness,
    input  logic                            rgb_valid,
    input  logic                            rgb_ready,
    input  hsl2rgb_pkg::chan_t              red,
    input  hsl2rgb_pkg::chan_t              green,
    input  hsl2rgb_pkg::chan_t              blue,
    output int                              errors,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import hsl2rgb_pkg::*;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    localparam longint PCT_FULL = longint'(100) << PCT_FRAC_BITS;
    localparam longint ONE = longint'(FRAC_ONE);
    localparam longint RAMP_DEN = longint'(RAMP_FULL) * ONE;

    rgb_t rgb_due[$];

    initial begin
        errors = 0;
        pending = 0;
    end

    // Percent with fraction bits -> unsigned Q1.16, saturating above 100%
    function automatic longint pct_to_unit(input logic [PCT_W-1:0] raw);
        longint v;
        v = longint'(raw);
        if (v > PCT_FULL)
            v = PCT_FULL;
        return (v << FRAC_BITS) / PCT_FULL;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v < 0)
            return 0;
        if (v > ONE)
            return ONE;
        return v;
    endfunction

    // Four-segment ramp for one channel angle, scaled to 8 bits, rounded
    function automatic chan_t ramp_channel(input int ang, input longint t1, input longint t2);
        longint base;
        longint num;
        longint r;
        int x;
        if (ang < 0)
            ang += int'(HUE_MAX);
        if (ang > int'(HUE_MAX))
            ang -= int'(HUE_MAX);
        if (ang < int'(SEG_RISE_END) ||
            (ang >= int'(SEG_FLAT_END) && ang < int'(SEG_FALL_END))) begin
            x = (ang < int'(SEG_RISE_END)) ? ang : int'(SEG_FALL_END) - ang;
            base = t2 * longint'(RAMP_FULL) + (t1 - t2) * longint'(x);
            if (base < 0)
                base = 0;
            num = base * longint'(SCALE_255);
        end
        else if (ang < int'(SEG_FLAT_END))
            num = t1 * longint'(RAMP_FULL) * longint'(SCALE_255);
        else
            num = t2 * longint'(RAMP_FULL) * longint'(SCALE_255);
        r = (num + RAMP_DEN / 2) / RAMP_DEN;
        if (r > longint'(CHAN_MAX))
            r = longint'(CHAN_MAX);
        return chan_t'(r);
    endfunction

    function automatic rgb_t convert_hsl(input logic [HUE_W-1:0] h,
                                         input logic [PCT_W-1:0] s_raw,
                                         input logic [PCT_W-1:0] l_raw);
        rgb_t px;
        longint s;
        longint l;
        longint ls;
        longint t1;
        longint t2;
        longint grey;
        int ang;
        s = pct_to_unit(s_raw);
        l = pct_to_unit(l_raw);
        ang = (h > HUE_MAX) ? int'(HUE_MAX) : int'(h);
        // zero saturation keys off the raw field and truncates
        if (s_raw == '0) begin
            grey = (l * longint'(SCALE_255)) >> FRAC_BITS;
            if (grey > longint'(CHAN_MAX))
                grey = longint'(CHAN_MAX);
            px.red = chan_t'(grey);
            px.green = chan_t'(grey);
            px.blue = chan_t'(grey);
            return px;
        end
        ls = (l * s) >> FRAC_BITS;
        if (l < longint'(FRAC_HALF))
            t1 = clamp_unit(l + ls);
        else
            t1 = clamp_unit(l + s - ls);
        t2 = clamp_unit(2 * l - t1);
        px.red = ramp_channel(ang + int'(HUE_THIRD), t1, t2);
        px.green = ramp_channel(ang, t1, t2);
        px.blue = ramp_channel(ang - int'(HUE_THIRD), t1, t2);
        return px;
    endfunction

    always @(posedge clk) begin
        rgb_t want;
        if (rst_n) begin
            if (rgb_valid && rgb_ready) begin
                if (rgb_due.size() == 0) begin
                    $error("rgb result with no request outstanding: %0d %0d %0d",
                           red, green, blue);
                    errors++;
                end
                else begin
                    want = rgb_due.pop_front();
                    if (red !== want.red) begin
                        $error("red: expected %0d, actual %0d", want.red, red);
                        errors++;
                    end
                    if (green !== want.green) begin
                        $error("green: expected %0d, actual %0d", want.green, green);
                        errors++;
                    end
                    if (blue !== want.blue) begin
                        $error("blue: expected %0d, actual %0d", want.blue, blue);
                        errors++;
                    end
                end
            end
            if (pix_valid && pix_ready)
                rgb_due.push_back(convert_hsl(hue, saturation, lightness));
            pending <= rgb_due.size();
        end
    end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the HSL to RGB converter: a directed sweep of hue segments,
// grey and out-of-range inputs, then random pixels in bursts while the
// result side stalls on shifting patterns. Checking lives in the scoreboard.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hsl2rgb_pkg::*;

    localparam int RANDOM_PIXELS = 950;
    localparam logic [PCT_W-1:0] PCT_TOP = 15'd25600;
    localparam logic [PCT_W-1:0] PCT_HALF = 15'd12800;
    localparam logic [PCT_W-1:0] PCT_ALL_ONES = '1;

    typedef enum logic [1:0] {SINK_FREE, SINK_COIN, SINK_SLOW, SINK_BEAT} sink_mode_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_ready;
    logic [HUE_W-1:0] hue = '0;
    logic [PCT_W-1:0] saturation = '0;
    logic [PCT_W-1:0] lightness = '0;
    logic rgb_valid;
    logic rgb_ready = 1'b0;
    chan_t red;
    chan_t green;
    chan_t blue;
    int errors;
    int pending;

    int burst_left = 0;
    sink_mode_e sink_mode = SINK_FREE;
    int sink_left = 0;
    int sink_phase = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hsl_to_rgb_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .rgb_valid  (rgb_valid),
        .rgb_ready  (rgb_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    hsl_rgb_scoreboard sb (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .rgb_valid  (rgb_valid),
        .rgb_ready  (rgb_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .errors     (errors),
        .pending    (pending)
    );

    // Result side: switches at random between stall patterns
    always @(posedge clk) begin
        if (sink_left == 0) begin
            sink_mode <= sink_mode_e'($urandom_range(0, 3));
            sink_left <= $urandom_range(32, 200);
        end
        else
            sink_left <= sink_left - 1;
        sink_phase <= sink_phase + 1;
        case (sink_mode)
            SINK_FREE: rgb_ready <= 1'b1;
            SINK_COIN: rgb_ready <= 1'($urandom_range(0, 1));
            SINK_SLOW: rgb_ready <= ($urandom_range(0, 3) == 0);
            default:   rgb_ready <= (sink_phase % 3 != 0);
        endcase
    end

    task automatic send_pixel(input logic [HUE_W-1:0] h,
                              input logic [PCT_W-1:0] s,
                              input logic [PCT_W-1:0] l);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        hue <= h;
        saturation <= s;
        lightness <= l;
        do
            @(posedge clk);
        while (!pix_ready);
    endtask

    // Hold off new requests until every outstanding result is back
    task automatic drain_pipeline();
        pix_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    function automatic logic [PCT_W-1:0] rand_pct(input bit allow_zero);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0 && allow_zero)
            return '0;
        else if (pick == 1)
            return PCT_W'($urandom_range(int'(PCT_TOP) + 1, int'(PCT_ALL_ONES)));
        else if (pick == 2)
            return PCT_W'($urandom_range(0, int'(PCT_ALL_ONES)));
        return PCT_W'($urandom_range(0, int'(PCT_TOP)));
    endfunction

    initial begin
        logic [HUE_W-1:0] h;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hue segment edges, full and half saturation
        send_pixel(9'd0, PCT_TOP, PCT_HALF);
        send_pixel(9'd1, PCT_TOP, PCT_HALF);
        send_pixel(SEG_RISE_END, PCT_TOP, PCT_HALF);
        send_pixel(HUE_THIRD, PCT_TOP, PCT_HALF);
        send_pixel(SEG_FLAT_END, PCT_TOP, PCT_HALF);
        send_pixel(HUE_TWO_THIRDS, PCT_TOP, PCT_HALF);
        send_pixel(9'd300, 15'd12800, 15'd6400);
        send_pixel(9'd359, PCT_TOP, 15'd19200);
        send_pixel(HUE_MAX, PCT_TOP, PCT_HALF);
        // hue above range
        send_pixel(9'd361, PCT_TOP, PCT_HALF);
        send_pixel(9'd511, 15'd20000, 15'd9000);
        // grey: truncated lightness
        send_pixel(9'd0, 15'd0, 15'd0);
        send_pixel(9'd200, 15'd0, PCT_HALF);
        send_pixel(9'd90, 15'd0, PCT_TOP);
        send_pixel(9'd511, 15'd0, PCT_ALL_ONES);
        // percent above range
        send_pixel(9'd30, PCT_ALL_ONES, 15'd8000);
        send_pixel(9'd210, 15'd25601, PCT_ALL_ONES);
        // lightness around one half
        send_pixel(9'd45, 15'd18000, 15'd12799);
        send_pixel(9'd225, 15'd18000, PCT_HALF);
        // dark and white with color
        send_pixel(9'd100, 15'd1, 15'd0);
        send_pixel(9'd100, PCT_TOP, PCT_TOP);
        send_pixel(9'd330, 15'd1, 15'd1);
        send_pixel(9'd15, 15'd16383, 15'd16384);

        drain_pipeline();

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if ($urandom_range(0, 19) == 0)
                h = HUE_W'($urandom_range(0, 511));
            else
                h = HUE_W'($urandom_range(0, int'(HUE_MAX)));
            send_pixel(h, rand_pct(1'b1), rand_pct(1'b0));
            if (i == 300 || i == 650)
                drain_pipeline();
        end

        drain_pipeline();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("hsl_to_rgb_converter verification clean");
        else
            $display("hsl_to_rgb_converter verification failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("hsl_to_rgb_converter verification failed");
        $finish;
    end

endmodule
